>>> sv/srrt_pkg.sv
package srrt_pkg;

  // Field widths fixed by the item and register layout
  localparam int CurW  = 16;
  localparam int TimeW = 32;
  localparam int PctW  = 8;
  localparam int StepW = 15;
  localparam int CntW  = 8;
  localparam int ProdW = 25;
  localparam int CmpW  = CurW + 1;

  localparam int InDataW  = 64;
  localparam int OutDataW = 56;

  // Threshold handling
  localparam logic [PctW-1:0]      PCT_FALLBACK = 8'd90;
  localparam logic [PctW-1:0]      PCT_LIMIT    = 8'd200;
  localparam logic signed [ProdW-1:0] MEAS_SCALE = 25'sd100;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    CFG_FRACTION = 2'd0,
    CFG_MIN_STEP = 2'd1,
    CFG_TIMEOUT  = 2'd2,
    CFG_CONFIRM  = 2'd3
  } cfg_idx_t;

  // Tracker phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_WAIT    = 4'b0010,
    PH_DONE    = 4'b0100,
    PH_TIMEOUT = 4'b1000
  } phase_t;

  // Reported track_state codes
  localparam logic [1:0] TRACK_IDLE    = 2'd0;
  localparam logic [1:0] TRACK_WAIT    = 2'd1;
  localparam logic [1:0] TRACK_DONE    = 2'd2;
  localparam logic [1:0] TRACK_TIMEOUT = 2'd3;

  typedef struct packed {
    logic [PctW-1:0]  fraction_percent;
    logic [StepW-1:0] min_step_ma;
    logic [TimeW-1:0] timeout_us;
    logic [CntW-1:0]  confirm_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    fraction_percent: 8'd75,
    min_step_ma:      15'd100,
    timeout_us:       32'd1000000,
    confirm_ticks:    8'd3
  };

  typedef struct packed {
    logic                    restart;
    logic signed [CurW-1:0]  reference_ma;
    logic signed [CurW-1:0]  measured_ma;
    logic [TimeW-1:0]        timestamp_us;
  } item_t;

  typedef struct packed {
    phase_t                  phase;
    logic                    armed;
    logic signed [CurW-1:0]  target_store;
    logic [TimeW-1:0]        start_time;
    logic [TimeW-1:0]        first_cross_time;
    logic [CntW-1:0]         cross_count;
    logic signed [CurW-1:0]  shown_target;
    logic [TimeW-1:0]        shown_time;
  } track_state_t;

  localparam track_state_t TRACK_RESET = '{
    phase:            PH_IDLE,
    armed:            1'b1,
    target_store:     '0,
    start_time:       '0,
    first_cross_time: '0,
    cross_count:      '0,
    shown_target:     '0,
    shown_time:       '1
  };

  // Map the one-hot phase to its reported code
  function automatic logic [1:0] phase_code(input phase_t p);
    logic [1:0] code;
    unique case (p)
      PH_IDLE:    code = TRACK_IDLE;
      PH_WAIT:    code = TRACK_WAIT;
      PH_DONE:    code = TRACK_DONE;
      PH_TIMEOUT: code = TRACK_TIMEOUT;
      default:    code = TRACK_IDLE;
    endcase
    return code;
  endfunction

endpackage

>>> sv/srrt_cfg.sv
module srrt_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [31:0]        wr_data,
  output srrt_pkg::cfg_t     cfg
);
  import srrt_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the register index and replace that field
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        CFG_FRACTION: cfg_nxt.fraction_percent = wr_data[PctW-1:0];
        CFG_MIN_STEP: cfg_nxt.min_step_ma      = wr_data[StepW-1:0];
        CFG_TIMEOUT:  cfg_nxt.timeout_us       = wr_data[TimeW-1:0];
        CFG_CONFIRM:  cfg_nxt.confirm_ticks    = wr_data[CntW-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> sv/srrt_step.sv
module srrt_step (
  input  srrt_pkg::cfg_t         cfg,
  input  srrt_pkg::item_t        item,
  input  srrt_pkg::track_state_t st,
  output srrt_pkg::track_state_t st_nxt
);
  import srrt_pkg::*;

  track_state_t              cur;
  logic [PctW-1:0]           pct_eff;
  logic signed [ProdW-1:0]   lhs;
  logic signed [ProdW-1:0]   rhs;
  logic                      crossed;
  logic [TimeW-1:0]          elapsed;
  logic                      expired;
  logic signed [CmpW-1:0]    ref_ext;
  logic signed [CmpW-1:0]    min_ext;
  logic                      big_step;
  logic [CntW-1:0]           cnt_inc;
  logic [TimeW-1:0]          first_nxt;

  // Restart wipes the tracker before this tick is evaluated
  assign cur = item.restart ? TRACK_RESET : st;

  // Zero or above-limit percent falls back to the PCT_FALLBACK threshold
  assign pct_eff = (cfg.fraction_percent == '0 || cfg.fraction_percent > PCT_LIMIT) ?
                   PCT_FALLBACK : cfg.fraction_percent;

  // Integer crossing test, direction follows the sign of the target
  assign lhs = ProdW'(item.measured_ma) * MEAS_SCALE;
  assign rhs = ProdW'(cur.target_store) * $signed({{(ProdW-PctW){1'b0}}, pct_eff});
  assign crossed = cur.target_store[CurW-1] ? (lhs <= rhs) : (lhs >= rhs);

  // Modulo-2^32 elapsed time since the start
  assign elapsed = item.timestamp_us - cur.start_time;
  assign expired = elapsed >= cfg.timeout_us;

  // Step magnitude check against the minimum
  assign ref_ext  = CmpW'(item.reference_ma);
  assign min_ext  = $signed({2'b00, cfg.min_step_ma});
  assign big_step = (ref_ext >= min_ext) || (ref_ext <= -min_ext);

  assign cnt_inc   = cur.cross_count + 1'b1;
  assign first_nxt = (cur.cross_count == '0) ? item.timestamp_us : cur.first_cross_time;

  always_comb begin
    st_nxt = cur;
    if (cur.phase == PH_WAIT) begin
      if (expired) begin
        st_nxt.phase      = PH_TIMEOUT;
        st_nxt.shown_time = '1;
      end else if (crossed) begin
        st_nxt.first_cross_time = first_nxt;
        st_nxt.cross_count      = cnt_inc;
        if (cnt_inc >= cfg.confirm_ticks) begin
          st_nxt.phase      = PH_DONE;
          st_nxt.shown_time = first_nxt;
        end
      end else begin
        st_nxt.cross_count      = '0;
        st_nxt.first_cross_time = '0;
      end
    end else if (cur.armed && big_step) begin
      st_nxt.phase            = PH_WAIT;
      st_nxt.armed            = 1'b0;
      st_nxt.target_store     = item.reference_ma;
      st_nxt.start_time       = item.timestamp_us;
      st_nxt.first_cross_time = '0;
      st_nxt.cross_count      = '0;
      st_nxt.shown_time       = '0;
      st_nxt.shown_target     = item.reference_ma;
    end
  end

endmodule

>>> sv/step_response_rise_time_tracker.sv
// Channel | Direction | Ports                         | Contents
// --------+-----------+-------------------------------+-----------------------------------
// in      | sink      | in_tvalid/tready/tdata/tuser  | one control-loop sample per transfer
// out     | source    | out_tvalid/tready/tdata       | tracker status after each sample
// cfg     | sink      | cfg_valid/ready/index/data    | register writes, always ready
//
// One sample per cycle is sustained while out_tready stays high.
// The input register feeds the tracker update, which writes state and result together.
// rst_n (synchronous, active low) restores register defaults and the idle, armed tracker.
// A stalled result holds in the output register while the input register still takes one
// more sample; after that in_tready drops until out_tready returns.
module step_response_rise_time_tracker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // [15:0] reference_ma, [31:16] measured_ma, [63:32] timestamp_us
  input  logic [srrt_pkg::InDataW-1:0] in_tdata,
  // [0] restart
  input  logic                         in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [1:0] track_state, [17:2] step_target_ma, [49:18] rise_time_us, [55:50] zero
  output logic [srrt_pkg::OutDataW-1:0] out_tdata,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [31:0]                  cfg_data
);
  import srrt_pkg::*;

  cfg_t         cfg;
  item_t        item_r;
  logic         in_vld_r;
  logic         in_vld_nxt;
  logic         in_take;
  logic         adv;
  track_state_t st_r;
  track_state_t st_nxt;
  logic         out_vld_r;
  logic         out_vld_nxt;
  logic [1:0]              res_state_r;
  logic signed [CurW-1:0]  res_target_r;
  logic [TimeW-1:0]        res_time_r;

  assign cfg_ready = 1'b1;

  srrt_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Advance the held sample whenever the output register is free or draining
  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Capture the incoming sample
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.restart      <= in_tuser;
      item_r.reference_ma <= in_tdata[15:0];
      item_r.measured_ma  <= in_tdata[31:16];
      item_r.timestamp_us <= in_tdata[63:32];
    end
  end

  srrt_step u_step (
    .cfg    (cfg),
    .item   (item_r),
    .st     (st_r),
    .st_nxt (st_nxt)
  );

  // Commit tracker state and handshake flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= TRACK_RESET;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (adv) begin
        st_r <= st_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (adv) begin
      res_state_r  <= phase_code(st_nxt.phase);
      res_target_r <= st_nxt.shown_target;
      res_time_r   <= st_nxt.shown_time;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OutDataW - 2 - CurW - TimeW){1'b0}}, res_time_r, res_target_r,
                       res_state_r};

endmodule

>>> bench/step_response_rise_time_tracker_test.sv
module step_response_rise_time_tracker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import srrt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 80;

  typedef struct {
    logic [1:0]         state;
    logic signed [15:0] target;
    logic [31:0]        rise_us;
  } status_t;

  // Mirror of the tracker: registers, tracking state and the statuses still owed
  class tracker_mirror;
    logic [7:0]         fraction;
    logic [14:0]        min_step;
    logic [31:0]        timeout;
    logic [7:0]         confirm;
    logic [1:0]         phase;
    bit                 armed;
    logic signed [15:0] target;
    logic signed [15:0] shown_target;
    logic [31:0]        start_time;
    logic [31:0]        first_cross;
    logic [31:0]        shown_time;
    logic [7:0]         cross_count;
    status_t            status_due[$];
    int                 errors;
    int                 checked;
    int                 starts;
    int                 dones;
    int                 timeouts;

    function new();
      fraction = CFG_RESET.fraction_percent;
      min_step = CFG_RESET.min_step_ma;
      timeout  = CFG_RESET.timeout_us;
      confirm  = CFG_RESET.confirm_ticks;
      clear_track();
    endfunction

    function void clear_track();
      phase        = TRACK_IDLE;
      armed        = 1'b1;
      target       = '0;
      start_time   = '0;
      first_cross  = '0;
      cross_count  = '0;
      shown_target = '0;
      shown_time   = '1;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [31:0] v);
      case (idx)
        CFG_FRACTION: fraction = v[7:0];
        CFG_MIN_STEP: min_step = v[14:0];
        CFG_TIMEOUT:  timeout  = v;
        CFG_CONFIRM:  confirm  = v[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return status_due.size();
    endfunction

    // Advance the tracker by one accepted sample and queue its status
    function void note_sample(bit restart, logic signed [15:0] ref_ma,
                              logic signed [15:0] meas_ma, logic [31:0] ts);
      longint      pct;
      longint      lhs;
      longint      rhs;
      int          r;
      int          lim;
      logic [31:0] elapsed;
      bit          crossed;
      status_t     s;
      r   = ref_ma;
      lim = min_step;
      pct = fraction;
      if (restart) clear_track();
      if (pct == 0 || pct > 200) pct = 90;
      if (phase == TRACK_WAIT) begin
        elapsed = ts - start_time;
        if (elapsed >= timeout) begin
          phase      = TRACK_TIMEOUT;
          shown_time = '1;
          timeouts++;
        end else begin
          lhs = meas_ma;
          lhs = lhs * 100;
          rhs = target;
          rhs = rhs * pct;
          crossed = (target >= 0) ? (lhs >= rhs) : (lhs <= rhs);
          if (crossed) begin
            if (cross_count == 0) first_cross = ts;
            cross_count = cross_count + 8'd1;
            if (cross_count >= confirm) begin
              phase      = TRACK_DONE;
              shown_time = first_cross;
              dones++;
            end
          end else begin
            cross_count = '0;
            first_cross = '0;
          end
        end
      end else if (armed && (r >= lim || r <= -lim)) begin
        phase        = TRACK_WAIT;
        armed        = 1'b0;
        target       = ref_ma;
        start_time   = ts;
        first_cross  = '0;
        cross_count  = '0;
        shown_time   = '0;
        shown_target = ref_ma;
        starts++;
      end
      s.state   = phase;
      s.target  = shown_target;
      s.rise_us = shown_time;
      status_due.push_back(s);
    endfunction

    // Compare one status transfer against the oldest owed status
    function void check_status(logic [OutDataW-1:0] d);
      status_t e;
      if (status_due.size() == 0) begin
        errors++;
        $display("%0t: status transfer %h with no sample outstanding", $time, d);
        return;
      end
      e = status_due.pop_front();
      checked++;
      if (d[1:0] !== e.state) begin
        errors++;
        $display("%0t: track_state expected %0d actual %0d", $time, e.state, d[1:0]);
      end
      if (d[17:2] !== e.target) begin
        errors++;
        $display("%0t: step_target_ma expected %0d actual %0d", $time, e.target,
                 $signed(d[17:2]));
      end
      if (d[49:18] !== e.rise_us) begin
        errors++;
        $display("%0t: rise_time_us expected %h actual %h", $time, e.rise_us, d[49:18]);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                in_tuser = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  cfg_idx_t            cfg_index = CFG_FRACTION;
  logic [31:0]         cfg_data = '0;

  tracker_mirror book = new();
  int          samples_sent = 0;
  int          settings_used = 0;
  int          cycle_count = 0;
  logic [31:0] now = '0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  step_response_rise_time_tracker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Cycle limit of %0d reached", CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Check every status transfer
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) book.check_status(out_tdata);
  end

  // Drive out_tready: random stall bursts, plus a long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offer one sample and hold it until the transfer; ends on a falling edge
  task automatic send_sample(bit restart, int ref_ma, int meas_ma, logic [31:0] ts);
    int                 gap;
    logic signed [15:0] rv;
    logic signed [15:0] mv;
    rv = ref_ma[15:0];
    mv = meas_ma[15:0];
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 11);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= restart;
    in_tdata  <= {ts, mv, rv};
    do @(posedge clk); while (!in_tready);
    book.note_sample(restart, rv, mv, ts);
    samples_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every owed status has come back
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (book.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_regs(int frac, int min_ma, logic [31:0] tmo, int conf);
    cfg_idx_t    regs[4] = '{CFG_FRACTION, CFG_MIN_STEP, CFG_TIMEOUT, CFG_CONFIRM};
    logic [31:0] vals[4];
    vals = '{frac, min_ma, tmo, conf};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      book.write_reg(regs[i], vals[i]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic advance(int dt_max);
    if ($urandom_range(0, 39) == 0) now += $urandom;
    else now += $urandom_range(1, dt_max);
  endtask

  // Reference too small to start a wait, or zero when the minimum is zero
  function automatic int quiet_ref(int min_i);
    int v;
    if (min_i == 0) return 0;
    v = $urandom_range(0, min_i - 1);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic int clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  // Restart, settle, step, then ramp the measured current toward the target
  task automatic run_episode(int len_max, int dt_max);
    int min_i;
    int tgt;
    int rise;
    int total;
    int lvl;
    int amp;
    int noise;
    int meas;
    int refv;
    bit rs;
    min_i = book.min_step;
    advance(dt_max);
    send_sample(1'b1, quiet_ref(min_i), $urandom, now);
    repeat ($urandom_range(0, 3)) begin
      advance(dt_max);
      send_sample(1'b0, quiet_ref(min_i), $urandom_range(0, 200) - 100, now);
    end
    tgt = ($urandom_range(0, 3) == 0) ? min_i : $urandom_range(min_i, 32767);
    if ($urandom_range(0, 1)) tgt = (tgt == 32767 && $urandom_range(0, 3) == 0) ? -32768 : -tgt;
    advance(dt_max);
    send_sample(1'b0, tgt, $urandom, now);
    rise  = $urandom_range(1, len_max / 4 + 1);
    total = $urandom_range(rise, len_max);
    amp   = (tgt < 0 ? -tgt : tgt) / 16 + 3;
    for (int k = 1; k <= total; k++) begin
      lvl   = (k < rise) ? k : rise;
      noise = $urandom_range(0, 2 * amp);
      noise = noise - amp;
      meas  = clamp16(longint'(tgt) * lvl * 11 / (rise * 10) + noise);
      if (k < rise && $urandom_range(0, 24) == 0) meas = 0;
      refv = ($urandom_range(0, 7) == 0) ? int'($urandom) : tgt;
      rs   = ($urandom_range(0, 79) == 0);
      advance(dt_max);
      send_sample(rs, refv, meas, now);
    end
  endtask

  task automatic run_phase(int frac, int min_ma, logic [31:0] tmo, int conf, int n,
                           int len_max, int dt_max);
    int first;
    set_regs(frac, min_ma, tmo, conf);
    first = samples_sent;
    while (samples_sent - first < n) begin
      if ($urandom_range(0, 4) == 0) begin
        // Unstructured samples with any bit pattern
        repeat ($urandom_range(1, 5)) begin
          advance(dt_max);
          send_sample($urandom_range(0, 15) == 0, $urandom, $urandom,
                      ($urandom_range(0, 3) == 0) ? $urandom : now);
        end
      end else begin
        run_episode(len_max, dt_max);
      end
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: idle below the minimum, negative step at exactly the minimum
    send_sample(1'b0, 99, 0, 32'd10);
    send_sample(1'b0, -100, 0, 32'd20);
    send_sample(1'b0, 0, -80, 32'd30);
    send_sample(1'b0, 0, -75, 32'd40);
    // Broken run clears the count, then a full confirm run latches its first time
    send_sample(1'b0, 0, 0, 32'd50);
    send_sample(1'b0, 0, -32768, 32'd60);
    send_sample(1'b0, 0, -32768, 32'd70);
    send_sample(1'b0, 0, -32768, 32'd80);
    // One-shot: done holds without a restart
    send_sample(1'b0, 32767, 0, 32'd90);
    // Crossing at time zero reads like waiting in the time field
    send_sample(1'b1, 32767, 32767, 32'd0);
    send_sample(1'b0, 0, 32767, 32'd0);
    send_sample(1'b0, 0, 32767, 32'd0);
    send_sample(1'b0, 0, 32767, 32'd0);
    // Timeout across the timestamp wrap, one tick short and then exact
    send_sample(1'b1, -32768, 0, 32'hFFFF_FFF0);
    send_sample(1'b0, 0, 0, 32'hFFFF_FFF0 + 32'd999_999);
    send_sample(1'b0, 0, 0, 32'hFFFF_FFF0 + 32'd1_000_000);
    send_sample(1'b1, 0, -1, 32'd5);

    // Zero percent, zero minimum, zero timeout, zero confirm
    set_regs(0, 0, 32'd0, 0);
    send_sample(1'b1, 0, 0, 32'd100);
    send_sample(1'b0, 0, -5, 32'd101);

    // Percent above the limit, largest minimum and timeout
    set_regs(255, 32767, 32'hFFFF_FFFF, 0);
    send_sample(1'b1, -32767, 0, 32'd200);
    send_sample(1'b0, 0, -29491, 32'd300);
    send_sample(1'b1, 32766, 0, 32'd400);

    // Randomized step responses over several register settings
    hold_req = 1'b1;
    run_phase(50, 500, 32'd5000, 2, 160, 30, 300);
    run_phase(200, 0, 32'd3000, 1, 120, 20, 250);
    run_phase(201, 32767, 32'hFFFF_FFFF, 4, 100, 20, 1000);
    hold_req = 1'b1;
    run_phase(1, 2000, 32'd800, 5, 150, 30, 80);
    run_phase(120, 50, 32'd0, 1, 60, 10, 10);
    run_phase(90, 300, 32'd100000, 255, 160, 300, 50);
    run_phase($urandom_range(0, 255), $urandom_range(0, 3000), $urandom_range(500, 20000),
              $urandom_range(1, 8), 100, 25, 400);
    quiet = 1'b1;
    run_phase(75, 100, 32'd1000000, 3, 150, 25, 200);

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Sent %0d samples under %0d register settings, %0d statuses checked",
             samples_sent, settings_used + 1, book.checked);
    $display("Tracker started %0d waits: %0d confirmed crossings, %0d timeouts",
             book.starts, book.dones, book.timeouts);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> step_response_rise_time_tracker.f
sv/srrt_pkg.sv
sv/srrt_cfg.sv
sv/srrt_step.sv
sv/step_response_rise_time_tracker.sv
bench/step_response_rise_time_tracker_test.sv
